FILE: hw/rtl/mabr_pkg.sv
// ----------------------------------------------------------------------------
// Moving average band reject package
// Shared widths, register addresses and transaction payload types.
// ----------------------------------------------------------------------------
package mabr_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WIN_W    = 5;
  localparam int unsigned LINE_AW  = 5;
  localparam int unsigned LINE_D   = 32;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned PEND_W   = 6;
  localparam int unsigned AGE_W    = 7;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned DIV_CW   = 5;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic REG_LOW_LEN  = 1'b0;
  localparam logic REG_HIGH_LEN = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_last;
  } out_item_t;

endpackage

FILE: hw/rtl/mabr_div.sv
// ----------------------------------------------------------------------------
// Moving average band reject divider
// Restoring divider of a window sum by the window length, one bit a cycle.
// ----------------------------------------------------------------------------
module mabr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mabr_pkg::SUM_W-1:0]     dividend_i,
  input  logic [mabr_pkg::WIN_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [mabr_pkg::SUM_W-1:0]     quotient_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [mabr_pkg::DIV_CW-1:0]    cnt_q;
  logic [mabr_pkg::WIN_W-1:0]     rem_q;
  logic [mabr_pkg::WIN_W-1:0]     div_q;
  logic [mabr_pkg::SUM_W-1:0]     quo_q;
  logic [mabr_pkg::WIN_W:0]       rem_sh;
  logic                           ge;
  logic [mabr_pkg::WIN_W:0]       rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[mabr_pkg::SUM_W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == mabr_pkg::DIV_CW'(mabr_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[mabr_pkg::WIN_W-1:0] : rem_sh[mabr_pkg::WIN_W-1:0];
      quo_q <= {quo_q[mabr_pkg::SUM_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/moving_average_band_reject.sv
// Each lowpass value and each result is summed and then divided through one shared
// serial divider, and each result also waits out any output stall; a steady-state
// sample costs both a lowpass value and a result.
// The last sample of a signal flushes all pending results, up to 30 of them.
// Throughput is one sample at a time; the input is stalled until the sequencer idles.
// Reset is asynchronous and active low; the sample lines need no clearing.
// ----------------------------------------------------------------------------
// Moving average band reject filter
// Two centred moving averages over sample and lowpass lines, sequenced serially.
// ----------------------------------------------------------------------------
module moving_average_band_reject (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mabr_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mabr_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mabr_pkg::ADDR_W-1:0]   paddr,
  input  logic [mabr_pkg::DATA_W-1:0]   pwdata,
  output logic [mabr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SUM, S_SUMEND, S_DIVGO, S_DIV,
    S_LSTORE, S_RC, S_RR, S_RW, S_OUT
  } state_e;

  localparam int unsigned SW = mabr_pkg::SAMPLE_W;

  function automatic logic signed [SW-1:0] sat(input logic signed [SW:0] v);
    logic signed [SW-1:0] r;
    if (v[SW] != v[SW-1]) begin
      r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  state_e                               state_q;
  logic [mabr_pkg::WIN_W-1:0]           low_win_q, high_win_q;
  logic [mabr_pkg::CNT_W-1:0]           seen_q, low_cnt_q;
  logic [mabr_pkg::LINE_AW-1:0]         raw_pos_q, low_pos_q;
  logic [mabr_pkg::PEND_W-1:0]          pend_low_q, pend_out_q;
  logic signed [SW-1:0]                 edge_first_q, low_first_q;
  logic                                 last_q, flush_q, op_res_q;
  logic [mabr_pkg::WIN_W-1:0]           j_q;
  logic signed [mabr_pkg::SUM_W-1:0]    acc_q;
  logic                                 neg_q;
  logic signed [SW-1:0]                 avg_q, band_q;
  logic                                 tap_vld_q, tap_sel_q, tap_edge_q;
  logic signed [SW-1:0]                 raw_rd_q, low_rd_q;
  logic                                 out_valid_q;
  mabr_pkg::out_item_t                  out_q;

  logic signed [SW-1:0]                 raw_mem [mabr_pkg::LINE_D];
  logic signed [SW-1:0]                 low_mem [mabr_pkg::LINE_D];

  logic                                 in_acc, cfg_wr;
  logic [mabr_pkg::WIN_W-1:0]           h_low, h_high, win_m1, op_win;
  logic signed [mabr_pkg::AGE_W-1:0]    age;
  logic                                 sel;
  logic [mabr_pkg::CNT_W-1:0]           age_pos, cnt_sel;
  logic [mabr_pkg::LINE_AW-1:0]         idx, rd_addr, pos_sel;
  logic                                 use_edge;
  logic signed [SW-1:0]                 tap_val;
  logic [mabr_pkg::SUM_W-1:0]           acc_mag, dividend;
  logic                                 div_start, div_done;
  logic [mabr_pkg::SUM_W-1:0]           quotient;
  logic signed [SW:0]                   quot_s;
  logic                                 need_low, need_res, final_res;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign h_low  = low_win_q >> 1;
  assign h_high = high_win_q >> 1;
  assign op_win = op_res_q ? high_win_q : low_win_q;
  assign win_m1 = op_win - 1'b1;

  always_comb begin
    age = '0;
    sel = 1'b0;
    case (state_q)
      S_SUM: begin
        sel = op_res_q;
        if (op_res_q) begin
          age = mabr_pkg::AGE_W'(pend_out_q) - 1'b1 + mabr_pkg::AGE_W'(h_high)
                - mabr_pkg::AGE_W'(j_q);
        end else begin
          age = mabr_pkg::AGE_W'(pend_low_q) - 1'b1 + mabr_pkg::AGE_W'(h_low)
                - mabr_pkg::AGE_W'(j_q);
        end
      end
      S_RC: begin
        sel = 1'b1;
        age = mabr_pkg::AGE_W'(pend_out_q) - 1'b1;
      end
      S_RR: begin
        sel = 1'b0;
        age = mabr_pkg::AGE_W'(pend_low_q) + mabr_pkg::AGE_W'(pend_out_q) - 1'b1;
      end
      default: begin
        age = '0;
        sel = 1'b0;
      end
    endcase
    age_pos  = age[mabr_pkg::AGE_W-1] ? '0 : age[mabr_pkg::AGE_W-2:0];
    cnt_sel  = sel ? low_cnt_q : seen_q;
    pos_sel  = sel ? low_pos_q : raw_pos_q;
    use_edge = age_pos >= cnt_sel;
    idx      = (age_pos > mabr_pkg::CNT_W'(mabr_pkg::LINE_D - 1)) ?
               mabr_pkg::LINE_AW'(mabr_pkg::LINE_D - 1) : age_pos[mabr_pkg::LINE_AW-1:0];
    rd_addr  = pos_sel - idx;
  end

  always_comb begin
    if (tap_edge_q) begin
      tap_val = tap_sel_q ? low_first_q : edge_first_q;
    end else begin
      tap_val = tap_sel_q ? low_rd_q : raw_rd_q;
    end
    acc_mag   = acc_q[mabr_pkg::SUM_W-1] ? mabr_pkg::SUM_W'(-acc_q) : mabr_pkg::SUM_W'(acc_q);
    dividend  = acc_mag + mabr_pkg::SUM_W'(op_win >> 1);
    div_start = state_q == S_DIVGO;
    quot_s    = neg_q ? -$signed(quotient[SW:0]) : $signed(quotient[SW:0]);
    need_low  = flush_q ? (pend_low_q != '0) : (pend_low_q > mabr_pkg::PEND_W'(h_low));
    need_res  = flush_q ? (pend_out_q != '0) : (pend_out_q > mabr_pkg::PEND_W'(h_high));
    final_res = last_q && (pend_low_q == '0) && (pend_out_q == mabr_pkg::PEND_W'(1));
  end

  mabr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (op_win),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_mem[raw_pos_q + 1'b1] <= in_data_i.in_sample;
    end
    raw_rd_q <= raw_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LSTORE) begin
      low_mem[low_pos_q + 1'b1] <= avg_q;
    end
    low_rd_q <= low_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      low_win_q    <= mabr_pkg::WIN_W'(1);
      high_win_q   <= mabr_pkg::WIN_W'(1);
      seen_q       <= '0;
      low_cnt_q    <= '0;
      raw_pos_q    <= '0;
      low_pos_q    <= '0;
      pend_low_q   <= '0;
      pend_out_q   <= '0;
      edge_first_q <= '0;
      low_first_q  <= '0;
      last_q       <= 1'b0;
      flush_q      <= 1'b0;
      op_res_q     <= 1'b0;
      j_q          <= '0;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      avg_q        <= '0;
      band_q       <= '0;
      tap_vld_q    <= 1'b0;
      tap_sel_q    <= 1'b0;
      tap_edge_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      tap_vld_q  <= state_q == S_SUM;
      tap_sel_q  <= sel;
      tap_edge_q <= use_edge;
      if (tap_vld_q) begin
        acc_q <= acc_q + mabr_pkg::SUM_W'(tap_val);
      end
      if (cfg_wr && pwdata[0]) begin
        if (paddr[2] == mabr_pkg::REG_LOW_LEN) begin
          low_win_q <= pwdata[mabr_pkg::WIN_W-1:0];
        end else begin
          high_win_q <= pwdata[mabr_pkg::WIN_W-1:0];
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            raw_pos_q  <= raw_pos_q + 1'b1;
            if (seen_q == '0) begin
              edge_first_q <= in_data_i.in_sample;
            end
            if (seen_q != '1) begin
              seen_q <= seen_q + 1'b1;
            end
            pend_low_q <= pend_low_q + 1'b1;
            last_q     <= in_data_i.in_last;
            flush_q    <= 1'b0;
            state_q    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          j_q   <= '0;
          acc_q <= '0;
          if (need_low) begin
            op_res_q <= 1'b0;
            state_q  <= S_SUM;
          end else if (need_res) begin
            op_res_q <= 1'b1;
            state_q  <= S_SUM;
          end else if (!flush_q && last_q) begin
            flush_q <= 1'b1;
          end else begin
            if (flush_q) begin
              seen_q     <= '0;
              low_cnt_q  <= '0;
              pend_low_q <= '0;
              pend_out_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_SUM: begin
          if (j_q == win_m1) begin
            state_q <= S_SUMEND;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_SUMEND: begin
          state_q <= S_DIVGO;
        end
        S_DIVGO: begin
          neg_q   <= acc_q[mabr_pkg::SUM_W-1];
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            avg_q   <= sat(quot_s);
            state_q <= op_res_q ? S_RC : S_LSTORE;
          end
        end
        S_LSTORE: begin
          low_pos_q <= low_pos_q + 1'b1;
          if (low_cnt_q == '0) begin
            low_first_q <= avg_q;
          end
          if (low_cnt_q != '1) begin
            low_cnt_q <= low_cnt_q + 1'b1;
          end
          pend_low_q <= pend_low_q - 1'b1;
          pend_out_q <= pend_out_q + 1'b1;
          state_q    <= S_DECIDE;
        end
        S_RC: begin
          state_q <= S_RR;
        end
        S_RR: begin
          band_q  <= sat({tap_val[SW-1], tap_val} - {avg_q[SW-1], avg_q});
          state_q <= S_RW;
        end
        S_RW: begin
          out_q.out_sample <= sat({tap_val[SW-1], tap_val} - {band_q[SW-1], band_q});
          out_q.out_last   <= final_res;
          out_valid_q      <= 1'b1;
          state_q          <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            pend_out_q  <= pend_out_q - 1'b1;
            state_q     <= S_DECIDE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == mabr_pkg::REG_LOW_LEN) ?
                       mabr_pkg::DATA_W'(low_win_q) : mabr_pkg::DATA_W'(high_win_q);

`ifndef SYNTH
  a_out_only_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OUT)
    else $error("Result shown outside the output state.");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.out_last) |=>
      (pend_low_q == '0 && pend_out_q == '0))
    else $error("Pending work left after the final result.");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("Divider finished immediately after start.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (in_stall_o && pend_low_q != '0))
    else $error("Accepted transaction did not start the sequencer.");
`endif

endmodule
